[rtl/agd_pkg.sv]
// ----------------------------------------------------------------------------
// Gain envelope decimator package
// Shared widths, mode codes, register indexes and the exponential point
// table.
// ----------------------------------------------------------------------------
package agd_pkg;

  localparam int GAIN_W  = 16;
  localparam int FRAME_W = 24;
  localparam int POINT_W = 7;
  localparam int INDEX_W = 6;
  localparam int PROG_W  = 7;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 24;

  // Audio kinds; any other code behaves as the average mode.
  localparam logic [1:0] KIND_PEAK_LIN = 2'd0;
  localparam logic [1:0] KIND_PEAK_EXP = 2'd1;
  localparam logic [1:0] KIND_AVG_LIN  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_AUDIO_KIND   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_TOTAL_FRAMES = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_POINT_COUNT  = 2'd2;

  localparam logic [6:0] POINT_MAX_VALUE = 7'd127;
  localparam logic [6:0] PROGRESS_MAX    = 7'd100;
  localparam logic [15:0] EXP_OFFSET     = 16'd100;

  // floor(10^(x/36)) for x from 0 to 75.
  localparam logic [6:0] EXP_TAB [76] = '{
    7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
    7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2,
    7'd3, 7'd3, 7'd3, 7'd3,
    7'd4, 7'd4, 7'd4, 7'd4,
    7'd5, 7'd5, 7'd5,
    7'd6, 7'd6,
    7'd7, 7'd7,
    7'd8, 7'd8,
    7'd9,
    7'd10, 7'd10, 7'd11, 7'd12, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
    7'd18, 7'd20, 7'd21, 7'd22, 7'd24, 7'd26,
    7'd27, 7'd29, 7'd31, 7'd33, 7'd35, 7'd38, 7'd40, 7'd43, 7'd46, 7'd49,
    7'd52, 7'd56, 7'd59, 7'd63, 7'd68, 7'd72,
    7'd77, 7'd82, 7'd87, 7'd93, 7'd100, 7'd106, 7'd113, 7'd121
  };

  // Exponential display value of a level. Beyond the point where the power
  // of ten no longer fits 15 bits the result is zero.
  function automatic logic [6:0] exp_point(input logic [15:0] level);
    logic [15:0] x;
    begin
      x = level - EXP_OFFSET;
      if (level < EXP_OFFSET) begin
        exp_point = 7'd0;
      end else if (x <= 16'd75) begin
        exp_point = EXP_TAB[x[6:0]];
      end else if (x <= 16'd162) begin
        exp_point = POINT_MAX_VALUE;
      end else begin
        exp_point = 7'd0;
      end
    end
  endfunction

endpackage

[rtl/agd_if.sv]
// ----------------------------------------------------------------------------
// Gain envelope decimator channels
// Valid/ready channels for frame items, display points and register writes.
// ----------------------------------------------------------------------------
interface agd_frame_if import agd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] gain;
  logic              gain_valid;
  logic              frame_last;
  logic [GAIN_W-1:0] frame_peak;
  logic              silent;
  logic              stream_end;

  modport source (output valid, gain, gain_valid, frame_last, frame_peak, silent,
                  stream_end, input ready);
  modport sink (input valid, gain, gain_valid, frame_last, frame_peak, silent,
                stream_end, output ready);
endinterface

interface agd_point_if import agd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POINT_W-1:0] point_value;
  logic [INDEX_W-1:0] point_index;
  logic [PROG_W-1:0]  progress;
  logic               run_last;

  modport source (output valid, point_value, point_index, progress, run_last,
                  input ready);
  modport sink (input valid, point_value, point_index, progress, run_last,
                output ready);
endinterface

interface agd_cfg_if import agd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] reg_index;
  logic [CFG_D_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

[rtl/audio_gain_envelope_decimator.sv]
// ----------------------------------------------------------------------------
// Audio gain envelope decimator
// Reduces per-frame gain values to a short row of display points.
// ----------------------------------------------------------------------------
// An item that does not close a pair of frames is taken without leaving the
// idle state, and so is every item once the block has finished. An item that
// closes a pair runs a sequencer around one shared 24x16 multiplier and one
// restoring divider that retires one quotient bit per cycle. Once the item is
// accepted the block is busy on the average level (average mode only), the
// processed mark, the linear point value (no division in the exponential mode
// or with a zero divisor) and the final mark check, so a closing pair that
// yields no point still keeps the frame channel stalled. Each point of a run
// adds a mark update and an output transfer, which waits for the sink, and a
// run with any point adds the progress figure ahead of its transfers. The
// frame channel is ready only while the sequencer is idle; the configuration
// channel is always ready and must only be written while idle.
module audio_gain_envelope_decimator
  import agd_pkg::*;
#(
  parameter int RESOLUTION = 1000,
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  agd_frame_if.sink   frames,
  agd_point_if.source points,
  agd_cfg_if.sink     cfg
);

  // Width of the shared divider's dividend and quotient.
  localparam int DIV_W = 40;
  localparam int DVS_W = 24;
  localparam int CNT_W = 6;

  localparam logic [15:0] RES    = 16'(RESOLUTION);
  localparam logic [6:0]  SIZE_MAX = 7'(MAX_POINTS);
  // Percent step; RESOLUTION is at least 100, so the step is never zero.
  localparam logic [DVS_W-1:0] STEP = DVS_W'(RESOLUTION / 100);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEVEL_DIV,
    ST_PROC_MUL,
    ST_PROC_DIV,
    ST_VAL_MUL,
    ST_VAL_DIV,
    ST_MARK_CHECK,
    ST_MARK_MUL,
    ST_MARK_DIV,
    ST_PROG_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]         audio_kind;
  logic [FRAME_W-1:0] total_frames;
  logic [6:0]         point_count;

  // Block state.
  logic [FRAME_W-1:0] frames_done;
  logic [6:0]         next_point;
  logic [15:0]        written_mark;
  logic [31:0]        gain_accum;
  logic [15:0]        gain_count;
  logic               second_of_pair;
  logic [15:0]        divisor_latch;
  logic               finished;

  // Working registers of one run.
  logic [15:0]       level;
  logic [DIV_W-1:0]  processed;
  logic [6:0]        point_value;
  logic [6:0]        emit_idx;
  logic [6:0]        progress;

  // Shared divider.
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] div_cnt;

  // Combinational helpers.
  logic              avg_mode;
  logic [6:0]        size;
  logic [FRAME_W-1:0] tf;
  logic [32:0]       accum_sum;
  logic [31:0]       accum_next;
  logic [15:0]       count_next;
  logic              in_xfer;
  logic              out_xfer;
  logic [23:0]       mul_a;
  logic [15:0]       mul_b;
  logic [DIV_W-1:0]  product;
  logic [DVS_W:0]    rem_shift;
  logic              rem_ge;
  logic [DVS_W-1:0]  rem_new;
  logic [DIV_W-1:0]  quo_new;
  logic              div_done;
  logic [6:0]        emit_idx_inc;

  assign avg_mode = !(audio_kind == KIND_PEAK_LIN || audio_kind == KIND_PEAK_EXP);
  assign size     = (point_count > SIZE_MAX) ? SIZE_MAX : point_count;
  assign tf       = (total_frames == '0) ? FRAME_W'(1) : total_frames;

  assign in_xfer  = frames.valid && frames.ready;
  assign out_xfer = points.valid && points.ready;

  assign frames.ready = (state == ST_IDLE);
  assign cfg.ready    = 1'b1;

  assign emit_idx_inc = emit_idx + 7'd1;

  assign points.valid       = (state == ST_EMIT);
  assign points.point_value = point_value;
  assign points.point_index = emit_idx[INDEX_W-1:0];
  assign points.progress    = progress;
  assign points.run_last    = (emit_idx_inc == next_point);

  // Gain accumulation of the accepted item: saturating sum and count in the
  // average mode, running maximum in the peak modes.
  always_comb begin
    accum_sum  = {1'b0, gain_accum} + {17'd0, frames.gain};
    accum_next = gain_accum;
    count_next = gain_count;
    if (!frames.silent && frames.gain_valid) begin
      if (avg_mode) begin
        accum_next = accum_sum[32] ? '1 : accum_sum[31:0];
        count_next = (gain_count != 16'hFFFF) ? gain_count + 16'd1 : gain_count;
      end else if ({16'd0, frames.gain} > gain_accum) begin
        accum_next = {16'd0, frames.gain};
      end
    end
  end

  // The one multiplier, shared by the processed mark, the linear point value
  // and the written mark.
  always_comb begin
    unique case (state)
      ST_VAL_MUL: begin
        mul_a = {8'd0, level};
        mul_b = {9'd0, POINT_MAX_VALUE};
      end
      ST_MARK_MUL: begin
        mul_a = {17'd0, next_point};
        mul_b = RES;
      end
      default: begin
        mul_a = frames_done;
        mul_b = RES;
      end
    endcase
    product = DIV_W'(mul_a) * DIV_W'(mul_b);
  end

  // One restoring division step per cycle. Dividends, but for the processed mark,
  // are loaded left-aligned so that only their significant bits are iterated.
  always_comb begin
    rem_shift = {rem, quo[DIV_W-1]};
    rem_ge    = rem_shift >= {1'b0, dvs};
    rem_new   = rem_ge ? DVS_W'(rem_shift - {1'b0, dvs}) : rem_shift[DVS_W-1:0];
    quo_new   = {quo[DIV_W-2:0], rem_ge};
    div_done  = (div_cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      audio_kind     <= KIND_PEAK_LIN;
      total_frames   <= FRAME_W'(1);
      point_count    <= 7'd64;
      frames_done    <= '0;
      next_point     <= '0;
      written_mark   <= '0;
      gain_accum     <= '0;
      gain_count     <= '0;
      second_of_pair <= 1'b0;
      divisor_latch  <= '0;
      finished       <= 1'b0;
      div_cnt        <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.reg_index)
          REG_AUDIO_KIND:   audio_kind   <= cfg.wdata[1:0];
          REG_TOTAL_FRAMES: total_frames <= cfg.wdata;
          REG_POINT_COUNT:  point_count  <= cfg.wdata[6:0];
          default: ;
        endcase
      end

      if (!div_done) begin
        rem     <= rem_new;
        quo     <= quo_new;
        div_cnt <= div_cnt - CNT_W'(1);
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer && !finished) begin
            if (next_point >= size || frames.stream_end) begin
              finished <= 1'b1;
            end else if (!frames.frame_last) begin
              gain_accum <= accum_next;
              gain_count <= count_next;
            end else begin
              divisor_latch <= frames.silent ? 16'd1 : frames.frame_peak;
              frames_done   <= frames_done + FRAME_W'(1);
              if (!second_of_pair) begin
                second_of_pair <= 1'b1;
                gain_accum     <= accum_next;
                gain_count     <= count_next;
              end else begin
                // The pair closes: take its level and start the run.
                second_of_pair <= 1'b0;
                gain_accum     <= '0;
                gain_count     <= '0;
                if (avg_mode && count_next != '0) begin
                  quo     <= {accum_next, 8'd0};
                  rem     <= '0;
                  dvs     <= {8'd0, count_next};
                  div_cnt <= CNT_W'(32);
                  state   <= ST_LEVEL_DIV;
                end else begin
                  level <= (accum_next[31:16] != '0) ? 16'hFFFF : accum_next[15:0];
                  state <= ST_PROC_MUL;
                end
              end
            end
          end
        end

        ST_LEVEL_DIV: begin
          if (div_done) begin
            level <= (quo[31:16] != '0) ? 16'hFFFF : quo[15:0];
            state <= ST_PROC_MUL;
          end
        end

        ST_PROC_MUL: begin
          quo     <= product;
          rem     <= '0;
          dvs     <= tf;
          div_cnt <= CNT_W'(DIV_W);
          state   <= ST_PROC_DIV;
        end

        ST_PROC_DIV: begin
          if (div_done) begin
            processed <= quo;
            state     <= ST_VAL_MUL;
          end
        end

        ST_VAL_MUL: begin
          if (audio_kind == KIND_PEAK_EXP) begin
            point_value <= exp_point(level);
            state       <= ST_MARK_CHECK;
          end else if (divisor_latch == '0) begin
            point_value <= '0;
            state       <= ST_MARK_CHECK;
          end else begin
            quo     <= {product[22:0], 17'd0};
            rem     <= '0;
            dvs     <= {8'd0, divisor_latch};
            div_cnt <= CNT_W'(23);
            state   <= ST_VAL_DIV;
          end
        end

        ST_VAL_DIV: begin
          if (div_done) begin
            point_value <= (quo[22:7] != '0) ? POINT_MAX_VALUE : quo[6:0];
            state       <= ST_MARK_CHECK;
          end
        end

        ST_MARK_CHECK: begin
          if ({24'd0, written_mark} <= processed && next_point < size) begin
            next_point <= next_point + 7'd1;
            state      <= ST_MARK_MUL;
          end else if (emit_idx == next_point) begin
            // No point in this run, so no progress figure either.
            state <= ST_IDLE;
          end else begin
            // Points of this run lie between emit_idx and next_point.
            quo     <= {written_mark, 24'd0};
            rem     <= '0;
            dvs     <= STEP;
            div_cnt <= CNT_W'(16);
            state   <= ST_PROG_DIV;
          end
        end

        ST_MARK_MUL: begin
          quo     <= {product[22:0], 17'd0};
          rem     <= '0;
          dvs     <= {17'd0, size};
          div_cnt <= CNT_W'(23);
          state   <= ST_MARK_DIV;
        end

        ST_MARK_DIV: begin
          if (div_done) begin
            written_mark <= quo[15:0];
            state        <= ST_MARK_CHECK;
          end
        end

        ST_PROG_DIV: begin
          if (div_done) begin
            progress <= (quo[15:7] != '0 || quo[6:0] > PROGRESS_MAX) ?
                        PROGRESS_MAX : quo[6:0];
            state    <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_xfer) begin
            emit_idx <= emit_idx_inc;
            if (emit_idx_inc == next_point) begin
              state <= ST_IDLE;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase

      if (state == ST_IDLE) begin
        // Runs always start at the next point to be written.
        emit_idx <= next_point;
      end
    end
  end

endmodule

[tb/sv/audio_gain_envelope_decimator_tb.sv]
// ----------------------------------------------------------------------------
// Audio gain envelope decimator testbench
// Feeds frame items and register writes into the decimator. An internal
// envelope predictor works out every display point, and each transfer on
// the point channel is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module audio_gain_envelope_decimator_tb;
  import agd_pkg::*;

  localparam int RESOLUTION = 1000;
  localparam int MAX_POINTS = 64;

  // Clock and run control.
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 140;
  localparam int LONG_HOLD = 500;
  localparam int BURST_HOLD = 300;

  // Register settings used by the phases.
  localparam logic [1:0]  KIND_SPARE  = 2'd3;        // undefined code, acts as average
  localparam logic [23:0] TF_NOMINAL  = 24'd150;
  localparam logic [23:0] TF_FAR      = 24'hFFFFFF;
  localparam logic [23:0] TF_ZERO     = 24'd0;
  localparam logic [23:0] TF_ONE      = 24'd1;
  localparam logic [23:0] PC_FULL     = 24'd64;
  localparam logic [23:0] PC_OVER     = 24'd100;
  localparam logic [23:0] PC_TOP      = 24'd127;
  localparam logic [23:0] PC_NONE     = 24'd0;

  // Arithmetic constants of the display mapping.
  localparam int VALUE_CEIL    = 127;
  localparam int PROGRESS_CEIL = 100;
  localparam int EXP_BASE      = 100;
  localparam int EXP_TAB_LAST  = 75;
  localparam int EXP_FIT_LAST  = 162;

  // floor(10^(x/36)) for x from 0 to 75.
  localparam byte unsigned TEN_POW_TAB [76] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
    2, 2, 2, 2, 2, 2, 2,
    3, 3, 3, 3,
    4, 4, 4, 4,
    5, 5, 5,
    6, 6,
    7, 7,
    8, 8,
    9,
    10, 10, 11, 12, 12, 13, 14, 15, 16, 17, 18, 20, 21, 22, 24, 26,
    27, 29, 31, 33, 35, 38, 40, 43, 46, 49, 52, 56, 59, 63, 68, 72,
    77, 82, 87, 93, 100, 106, 113, 121
  };

  typedef struct {
    logic [GAIN_W-1:0] gain;
    logic              gain_valid;
    logic              frame_last;
    logic [GAIN_W-1:0] frame_peak;
    logic              silent;
    logic              stream_end;
  } frame_item_t;

  typedef struct {
    logic [POINT_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic [PROG_W-1:0]  progress;
    logic               run_last;
  } display_point_t;

  logic clk = 1'b0;
  logic rst;

  agd_frame_if frames_ch ();
  agd_point_if points_ch ();
  agd_cfg_if   cfg_ch ();

  audio_gain_envelope_decimator #(
    .RESOLUTION (RESOLUTION),
    .MAX_POINTS (MAX_POINTS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .frames (frames_ch),
    .points (points_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies, starting at their reset values.
  logic [1:0]  env_kind   = KIND_PEAK_LIN;
  logic [23:0] env_total  = 24'd1;
  logic [6:0]  env_points = 7'd64;

  // Predictor state, all starting cleared.
  logic [23:0] frames_seen  = '0;
  logic [6:0]  points_sent  = '0;
  logic [15:0] mark_reached = '0;
  logic [31:0] level_accum  = '0;
  logic [15:0] level_count  = '0;
  logic        pair_open    = 1'b0;
  logic [15:0] peak_latch   = '0;
  logic        stream_done  = 1'b0;

  display_point_t pending_points [$];
  int fault_count = 0;
  int cycle_count = 0;

  // Pacing of both channels. steady_mode switches off all random gaps.
  // A test asks for a long receiver stall by setting hold_len and bumping
  // hold_req; the sink process loads sink_hold from it and counts it down.
  bit steady_mode = 1'b0;
  int hold_len = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int sink_hold = 0;
  int sink_wait = 0;

  // --------------------------------------------------------------------------
  // Envelope predictor
  // --------------------------------------------------------------------------

  function automatic logic [6:0] ten_pow_point(input longint unsigned level);
    longint unsigned x;
    if (level < EXP_BASE) begin
      return '0;
    end
    x = level - EXP_BASE;
    if (x <= EXP_TAB_LAST) begin
      return 7'(TEN_POW_TAB[x]);
    end else if (x <= EXP_FIT_LAST) begin
      return 7'(VALUE_CEIL);
    end
    // The power no longer fits 15 bits, so the display shows nothing.
    return '0;
  endfunction

  function automatic logic [6:0] linear_point(input longint unsigned level,
                                              input longint unsigned divisor);
    longint unsigned v;
    if (divisor == 0) begin
      return '0;
    end
    v = (VALUE_CEIL * level) / divisor;
    return (v > VALUE_CEIL) ? 7'(VALUE_CEIL) : 7'(v);
  endfunction

  // Advances the envelope by one accepted frame item and queues the points
  // that it releases.
  task automatic predict_frame(input frame_item_t it);
    int unsigned size;
    bit averaging;
    longint unsigned sum;
    longint unsigned level;
    longint unsigned tf;
    longint unsigned processed;
    longint unsigned prog;
    display_point_t run [$];
    display_point_t pt;
    if (stream_done) begin
      return;
    end
    size = (env_points > MAX_POINTS) ? MAX_POINTS : 32'(env_points);
    if (points_sent >= size || it.stream_end) begin
      stream_done = 1'b1;
      return;
    end
    averaging = !(env_kind == KIND_PEAK_LIN || env_kind == KIND_PEAK_EXP);
    if (!it.silent && it.gain_valid) begin
      if (averaging) begin
        sum = longint'(level_accum) + it.gain;
        level_accum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        if (level_count != 16'hFFFF) begin
          level_count++;
        end
      end else if (it.gain > level_accum) begin
        level_accum = {16'd0, it.gain};
      end
    end
    if (!it.frame_last) begin
      return;
    end
    peak_latch = it.silent ? 16'd1 : it.frame_peak;
    frames_seen = frames_seen + 24'd1;
    if (!pair_open) begin
      pair_open = 1'b1;
      return;
    end
    pair_open = 1'b0;

    level = 64'(level_accum);
    if (averaging && level_count != 0) begin
      level = 64'(level_accum / level_count);
    end
    if (level > 16'hFFFF) begin
      level = 16'hFFFF;
    end
    level_accum = '0;
    level_count = '0;

    tf = (env_total == '0) ? 64'd1 : 64'(env_total);
    processed = (longint'(frames_seen) * RESOLUTION) / tf;
    while (mark_reached <= processed && points_sent < size) begin
      pt.value = (env_kind == KIND_PEAK_EXP) ? ten_pow_point(level)
                                             : linear_point(level, 64'(peak_latch));
      pt.index = points_sent[5:0];
      run.push_back(pt);
      points_sent++;
      mark_reached = 16'((longint'(RESOLUTION) * points_sent) / size);
    end

    prog = 64'(mark_reached / (RESOLUTION / 100));
    if (prog > PROGRESS_CEIL) begin
      prog = 64'(PROGRESS_CEIL);
    end
    foreach (run[k]) begin
      run[k].progress = 7'(prog);
      run[k].run_last = (k == run.size() - 1);
      pending_points.push_back(run[k]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Point channel: random receiver pacing and the field-by-field check
  // --------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  task automatic check_point();
    display_point_t want;
    if (pending_points.size() == 0) begin
      $display("%0t: point %0d arrived with nothing expected", $time,
               points_ch.point_index);
      fault_count++;
      return;
    end
    want = pending_points.pop_front();
    compare_field("point_value", 8'(want.value), 8'(points_ch.point_value));
    compare_field("point_index", 8'(want.index), 8'(points_ch.point_index));
    compare_field("progress", 8'(want.progress), 8'(points_ch.progress));
    compare_field("run_last", 8'(want.run_last), 8'(points_ch.run_last));
  endtask

  // Outputs are read at the rising edge, before the block's own updates of
  // that edge take effect, so a transfer is seen exactly once.
  always @(posedge clk) begin
    if (rst) begin
      points_ch.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        sink_hold = hold_len;
      end
      if (points_ch.valid && points_ch.ready) begin
        check_point();
        sink_wait = steady_mode ? 0 : int'($urandom_range(0, 4));
      end
      if (sink_hold > 0) begin
        sink_hold--;
        points_ch.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        points_ch.ready <= 1'b0;
      end else begin
        points_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("audio_gain_envelope_decimator_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Frame and register channels
  // --------------------------------------------------------------------------

  function automatic frame_item_t item_of(input int gain, input bit gain_valid,
                                          input bit frame_last, input int peak,
                                          input bit silent, input bit stream_end);
    frame_item_t it;
    it.gain       = 16'(gain);
    it.gain_valid = gain_valid;
    it.frame_last = frame_last;
    it.frame_peak = 16'(peak);
    it.silent     = silent;
    it.stream_end = stream_end;
    return it;
  endfunction

  // Offers one item after a random gap and returns at the edge of its
  // transfer. Valid is left high so that a following item with no gap is
  // offered straight away.
  task automatic send_frame(input frame_item_t it);
    int gap;
    gap = steady_mode ? 0 : int'($urandom_range(0, 4));
    if (gap != 0) begin
      frames_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frames_ch.valid      <= 1'b1;
    frames_ch.gain       <= it.gain;
    frames_ch.gain_valid <= it.gain_valid;
    frames_ch.frame_last <= it.frame_last;
    frames_ch.frame_peak <= it.frame_peak;
    frames_ch.silent     <= it.silent;
    frames_ch.stream_end <= it.stream_end;
    @(posedge clk);
    while (!frames_ch.ready) @(posedge clk);
    predict_frame(it);
  endtask

  // One register transfer; valid is left high for a write that follows.
  task automatic push_reg(input logic [CFG_A_W-1:0] idx, input logic [23:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_AUDIO_KIND:   env_kind = data[1:0];
      REG_TOTAL_FRAMES: env_total = data[23:0];
      REG_POINT_COUNT:  env_points = data[6:0];
      default: ;
    endcase
  endtask

  task automatic write_one_reg(input logic [CFG_A_W-1:0] idx, input logic [23:0] data);
    push_reg(idx, data);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [1:0] kind, input logic [23:0] total,
                              input logic [23:0] count);
    push_reg(REG_AUDIO_KIND, 24'(kind));
    push_reg(REG_TOTAL_FRAMES, total);
    push_reg(REG_POINT_COUNT, count);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers may only change while the block is idle. An item that yields
  // no point can still keep the sequencer busy after the last point, so a
  // fixed settling time follows the last expected transfer.
  task automatic wait_idle();
    frames_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Changes the pacing between edges; only called while no item is offered.
  task automatic set_pace(input bit steady, input int hold);
    @(negedge clk);
    steady_mode = steady;
    hold_len = hold;
    hold_req++;
    @(posedge clk);
  endtask

  function automatic frame_item_t random_item(input logic [1:0] kind);
    frame_item_t it;
    case ($urandom_range(0, 7))
      0: it.gain = 16'($urandom());
      1: it.gain = 16'($urandom_range(0, 255));
      default: it.gain = 16'((kind == KIND_PEAK_EXP) ? $urandom_range(80, 280)
                                                     : $urandom_range(0, 2000));
    endcase
    it.frame_peak = 16'(($urandom_range(0, 7) == 0) ? $urandom()
                                                    : $urandom_range(0, 2500));
    if ($urandom_range(0, 15) == 0) begin
      it.frame_peak = '0;
    end
    it.gain_valid = ($urandom_range(0, 7) != 0);
    it.frame_last = 1'($urandom_range(0, 1));
    it.silent     = ($urandom_range(0, 9) == 0);
    it.stream_end = 1'b0;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Kind and point count stay at their reset values here, so the first runs
  // also show that the block comes out of reset in peak linear mode with 64
  // points. Each pair closes with roughly one point at 150 frames.
  task automatic test_peak_linear();
    write_one_reg(REG_TOTAL_FRAMES, TF_NOMINAL);
    // Full-scale gain over a silent closing frame: divisor 1, value clamps.
    send_frame(item_of(0, 1, 0, 0, 0, 0));
    send_frame(item_of(16'hFFFF, 1, 1, 16'hFFFF, 0, 0));
    send_frame(item_of(16'hFFFF, 1, 1, 0, 1, 0));
    // Zero peak on the closing frame divides by zero and shows nothing.
    send_frame(item_of(300, 1, 1, 600, 0, 0));
    send_frame(item_of(100, 0, 1, 0, 0, 0));
    // Only the second frame's peak is used as divisor.
    send_frame(item_of(200, 1, 1, 9, 0, 0));
    send_frame(item_of(50, 1, 1, 400, 0, 0));
  endtask

  // Levels just below the table, at its start, at its end and past the
  // point where the power overflows.
  task automatic test_peak_exponential();
    wait_idle();
    write_one_reg(REG_AUDIO_KIND, 24'(KIND_PEAK_EXP));
    send_frame(item_of(99, 1, 1, 1, 0, 0));
    send_frame(item_of(0, 0, 1, 0, 1, 0));
    send_frame(item_of(100, 1, 1, 0, 0, 0));
    send_frame(item_of(0, 0, 1, 0, 0, 0));
    send_frame(item_of(175, 1, 1, 5, 0, 0));
    send_frame(item_of(3, 1, 1, 5, 0, 0));
    send_frame(item_of(263, 1, 1, 0, 0, 0));
    send_frame(item_of(0, 0, 1, 0, 1, 0));
  endtask

  // Averages over two counted gains, ignoring a silent item's gain, then a
  // pair in which no gain counts at all.
  task automatic test_average();
    wait_idle();
    write_one_reg(REG_AUDIO_KIND, 24'(KIND_AVG_LIN));
    send_frame(item_of(1000, 1, 0, 0, 0, 0));
    send_frame(item_of(2001, 1, 1, 3000, 0, 0));
    send_frame(item_of(9, 1, 1, 0, 1, 0));
    send_frame(item_of(50000, 0, 1, 700, 0, 0));
    send_frame(item_of(123, 0, 1, 700, 0, 0));
  endtask

  // A sum built up in average mode and closed in peak mode is taken as the
  // level directly, which overflows 16 bits and has to clamp.
  task automatic test_mode_switch_clamp();
    wait_idle();
    write_one_reg(REG_AUDIO_KIND, 24'(KIND_AVG_LIN));
    send_frame(item_of(16'hFFFF, 1, 0, 0, 0, 0));
    send_frame(item_of(16'hFFFF, 1, 0, 0, 0, 0));
    send_frame(item_of(16'hFFFF, 1, 1, 0, 0, 0));
    wait_idle();
    write_one_reg(REG_AUDIO_KIND, 24'(KIND_PEAK_LIN));
    send_frame(item_of(5, 1, 1, 16'hFFFF, 0, 0));
  endtask

  // With the largest frame total the processed mark stays at zero, so a
  // pair releases nothing. The point count above the maximum acts as 64.
  task automatic test_far_total_frames();
    wait_idle();
    program_regs(KIND_PEAK_LIN, TF_FAR, PC_TOP);
    send_frame(item_of(40000, 1, 1, 50000, 0, 0));
    send_frame(item_of(0, 0, 1, 0, 1, 0));
  endtask

  // Four blocks, one per kind code. The second block starts with a long
  // receiver stall so that a run backs up and the frame channel blocks; the
  // third block runs with no gaps on either side.
  task automatic test_random_stream();
    logic [1:0] kinds [4];
    kinds = '{KIND_AVG_LIN, KIND_PEAK_LIN, KIND_SPARE, KIND_PEAK_EXP};
    for (int b = 0; b < 4; b++) begin
      wait_idle();
      program_regs(kinds[b], TF_NOMINAL, (b == 0) ? PC_OVER : PC_FULL);
      set_pace(b == 2, (b == 1) ? LONG_HOLD : 0);
      repeat (RANDOM_ITEMS / 4) send_frame(random_item(kinds[b]));
    end
  endtask

  // A zero frame total counts as one, so the next closing pair pushes the
  // processed mark past the end and every remaining point comes in one run,
  // here against a stalled receiver.
  task automatic test_final_burst();
    wait_idle();
    program_regs(KIND_PEAK_LIN, TF_ZERO, PC_FULL);
    set_pace(1'b0, BURST_HOLD);
    send_frame(item_of(1234, 1, 1, 0, 0, 0));
    send_frame(item_of(777, 1, 1, 2000, 0, 0));
  endtask

  // Once all points are out, the next item stops the block; after that a
  // stream end and a zero point count change nothing.
  task automatic test_termination();
    wait_idle();
    send_frame(item_of(4321, 1, 1, 9000, 0, 0));
    send_frame(item_of(16'hFFFF, 1, 1, 16'hFFFF, 1, 1));
    wait_idle();
    program_regs(KIND_PEAK_EXP, TF_ONE, PC_NONE);
    send_frame(item_of(150, 1, 1, 10, 0, 0));
  endtask

  initial begin
    rst                  <= 1'b1;
    frames_ch.valid      <= 1'b0;
    frames_ch.gain       <= '0;
    frames_ch.gain_valid <= 1'b0;
    frames_ch.frame_last <= 1'b0;
    frames_ch.frame_peak <= '0;
    frames_ch.silent     <= 1'b0;
    frames_ch.stream_end <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.reg_index     <= '0;
    cfg_ch.wdata         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_peak_linear();
    test_peak_exponential();
    test_average();
    test_mode_switch_clamp();
    test_far_total_frames();
    test_random_stream();
    test_final_burst();
    test_termination();
    wait_idle();

    if (fault_count == 0) begin
      $display("audio_gain_envelope_decimator_tb: done, clean");
    end else begin
      $display("audio_gain_envelope_decimator_tb: done, errors");
    end
    $finish;
  end

endmodule
